>>> sv/websocket_client_frame_deframer_assert.svh
// Assertion macros shared by the deframer modules.
`ifndef WEBSOCKET_CLIENT_FRAME_DEFRAMER_ASSERT_SVH
`define WEBSOCKET_CLIENT_FRAME_DEFRAMER_ASSERT_SVH

`ifndef SYNTH
`define WSD_ASSERT(lbl, clk, rst_n, prop) \
lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
else $error("wsd assertion failed");
`define WSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
else $error("wsd assertion failed");
`else
`define WSD_ASSERT(lbl, clk, rst_n, prop)
`define WSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

>>> sv/wsd_pkg.sv
package wsd_pkg;

	localparam int LEN_W = 63;
	localparam int RUN_IDX_W = 3;

	// Frame opcodes.
	localparam logic [3:0] OP_CONT  = 4'h0;
	localparam logic [3:0] OP_TEXT  = 4'h1;
	localparam logic [3:0] OP_BIN   = 4'h2;
	localparam logic [3:0] OP_CLS   = 4'h8;
	localparam logic [3:0] OP_PING  = 4'h9;
	localparam logic [3:0] OP_PONG  = 4'hA;

	// Result channels.
	localparam logic [1:0] CH_DATA  = 2'd0;
	localparam logic [1:0] CH_REPLY = 2'd1;
	localparam logic [1:0] CH_END   = 2'd2;

	// End reasons.
	localparam logic [1:0] END_NONE  = 2'd0;
	localparam logic [1:0] END_PEER  = 2'd1;
	localparam logic [1:0] END_PROTO = 2'd2;
	localparam logic [1:0] END_TEXT  = 2'd3;

	// Close status codes.
	localparam logic [15:0] CODE_NORMAL   = 16'd1000;
	localparam logic [15:0] CODE_PROTOCOL = 16'd1002;
	localparam logic [15:0] CODE_UNSUPP   = 16'd1003;

	// Header bits and length markers.
	localparam logic [6:0] LEN_EXT16     = 7'd126;
	localparam logic [6:0] LEN_EXT64     = 7'd127;
	localparam logic [3:0] EXT16_BYTES   = 4'd2;
	localparam logic [3:0] EXT64_BYTES   = 4'd8;
	localparam logic [LEN_W-1:0] CTRL_MAX_LEN = 63'd125;

	// Reply frame bytes.
	localparam logic [7:0] PONG_HDR  = 8'h8A;
	localparam logic [7:0] CLOSE_HDR = 8'h88;
	localparam logic [7:0] CLOSE_LEN = 8'h02;

	// Positions within a run of results.
	localparam logic [RUN_IDX_W-1:0] POS_FIRST   = 3'd0;
	localparam logic [RUN_IDX_W-1:0] POS_SECOND  = 3'd1;
	localparam logic [RUN_IDX_W-1:0] POS_CODE_HI = 3'd2;
	localparam logic [RUN_IDX_W-1:0] POS_CODE_LO = 3'd3;
	localparam logic [RUN_IDX_W-1:0] POS_END     = 3'd4;

	typedef enum logic [4:0] {
		PH_HDR0    = 5'b00001,
		PH_HDR1    = 5'b00010,
		PH_EXTLEN  = 5'b00100,
		PH_MASK    = 5'b01000,
		PH_PAYLOAD = 5'b10000
	} phase_t;

	typedef enum logic [2:0] {
		RUN_BYTE  = 3'b001,
		RUN_PONG  = 3'b010,
		RUN_CLOSE = 3'b100
	} run_kind_t;

	// One input byte's worth of results, expanded by the emitter.
	typedef struct packed {
		run_kind_t   kind;
		logic        chan_reply;
		logic [7:0]  data;
		logic [15:0] code;
		logic [1:0]  reason;
	} run_t;

	function automatic logic [7:0] wsd_mask_byte(input logic [31:0] key,
		input logic [1:0] idx);
		logic [7:0] r;
		case (idx)
			2'd0: r = key[31:24];
			2'd1: r = key[23:16];
			2'd2: r = key[15:8];
			default: r = key[7:0];
		endcase
		return r;
	endfunction

endpackage

>>> sv/websocket_client_frame_deframer.sv
// Channel  Handshake             Beat contents
// rx       rx_valid / rx_stall   rx_byte
// res      res_valid / res_stall channel, out_byte, end_reason, last_of_run
//
// A received byte is parsed in the cycle it is taken and its results are loaded
// into the run register; results leave one per cycle from there while res_stall is low.
// A byte that causes one result or none is taken every cycle while res_stall is low;
// a pong header or a close reply stalls rx until its run's last beat leaves the single output.
// rx_stall rises while a run still has beats left after the current cycle.
// Reset puts the parser at the first header byte with the connection open.
module websocket_client_frame_deframer import wsd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       rx_valid,
	output logic       rx_stall,
	input  logic [7:0] rx_byte,
	output logic       res_valid,
	input  logic       res_stall,
	output logic [1:0] channel,
	output logic [7:0] out_byte,
	output logic [1:0] end_reason,
	output logic       last_of_run
);

	logic accept;
	logic run_new;
	run_t run_d;

	assign accept = rx_valid && !rx_stall;

	wsd_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.rx_byte (rx_byte),
		.run_new (run_new),
		.run_d   (run_d)
	);

	wsd_emitter u_emitter (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (accept && run_new),
		.run_d       (run_d),
		.busy        (rx_stall),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.channel     (channel),
		.out_byte    (out_byte),
		.end_reason  (end_reason),
		.last_of_run (last_of_run)
	);

endmodule

>>> sv/wsd_parser.sv
module wsd_parser import wsd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] rx_byte,
	output logic       run_new,
	output run_t       run_d
);

	`include "websocket_client_frame_deframer_assert.svh"

	logic              ended_q, ended_d;
	phase_t            phase_q, phase_d;
	logic [3:0]        opcode_q, opcode_d;
	logic              fin_q, fin_d;
	logic [3:0]        len_left_q, len_left_d;
	logic [1:0]        mask_idx_q, mask_idx_d;
	logic [1:0]        seen_q, seen_d;
	logic [LEN_W-1:0]  plen_q, plen_d;
	logic [LEN_W-1:0]  prem_q, prem_d;
	logic [31:0]       key_q, key_d;
	logic [15:0]       code_q, code_d;

	logic              fin_req, ld_req, hd_req, peer_req;
	logic [15:0]       fin_code;
	logic [1:0]        fin_reason;
	logic [LEN_W-1:0]  ld_len;
	logic [LEN_W-1:0]  plen_shift;
	logic [LEN_W-1:0]  prem_dec;
	logic [3:0]        len_left_dec;
	logic [1:0]        mask_idx_inc;
	logic [7:0]        unmasked;
	logic              op_known;

	assign plen_shift   = {plen_q[LEN_W-9:0], rx_byte};
	assign prem_dec     = prem_q - 63'd1;
	assign len_left_dec = len_left_q - 4'd1;
	assign mask_idx_inc = mask_idx_q + 2'd1;
	assign unmasked     = rx_byte ^ wsd_mask_byte(key_q, mask_idx_q);
	assign op_known     = (opcode_q == OP_CONT) || (opcode_q == OP_BIN) ||
		(opcode_q == OP_CLS) || (opcode_q == OP_PING) || (opcode_q == OP_PONG);

	always_comb begin
		ended_d    = ended_q;
		phase_d    = phase_q;
		opcode_d   = opcode_q;
		fin_d      = fin_q;
		len_left_d = len_left_q;
		mask_idx_d = mask_idx_q;
		seen_d     = seen_q;
		plen_d     = plen_q;
		prem_d     = prem_q;
		key_d      = key_q;
		code_d     = code_q;
		fin_req    = 1'b0;
		fin_code   = CODE_PROTOCOL;
		fin_reason = END_PROTO;
		ld_req     = 1'b0;
		ld_len     = plen_q;
		hd_req     = 1'b0;
		peer_req   = 1'b0;
		run_new    = 1'b0;
		run_d      = '{kind: RUN_BYTE, chan_reply: 1'b0, data: 8'h00,
			code: CODE_NORMAL, reason: END_NONE};

		if (!ended_q) begin
			case (phase_q)
				PH_HDR0: begin
					opcode_d   = rx_byte[3:0];
					fin_d      = rx_byte[7];
					// Reserved bits are parked here until the second header byte.
					len_left_d = {3'b000, |rx_byte[6:4]};
					phase_d    = PH_HDR1;
				end
				PH_HDR1: begin
					if ((len_left_q != 4'd0) || !rx_byte[7]) begin
						fin_req = 1'b1;
					end else if (rx_byte[6:0] == LEN_EXT16) begin
						plen_d     = '0;
						len_left_d = EXT16_BYTES;
						phase_d    = PH_EXTLEN;
					end else if (rx_byte[6:0] == LEN_EXT64) begin
						plen_d     = '0;
						len_left_d = EXT64_BYTES;
						phase_d    = PH_EXTLEN;
					end else begin
						plen_d     = {{(LEN_W-7){1'b0}}, rx_byte[6:0]};
						len_left_d = 4'd0;
						ld_req     = 1'b1;
						ld_len     = plen_d;
					end
				end
				PH_EXTLEN: begin
					if ((len_left_q == EXT64_BYTES) && rx_byte[7]) begin
						fin_req = 1'b1;
					end else begin
						plen_d     = plen_shift;
						len_left_d = len_left_dec;
						if (len_left_dec == 4'd0) begin
							ld_req = 1'b1;
							ld_len = plen_shift;
						end
					end
				end
				PH_MASK: begin
					key_d      = {key_q[23:0], rx_byte};
					mask_idx_d = mask_idx_inc;
					hd_req     = (mask_idx_inc == 2'd0);
				end
				PH_PAYLOAD: begin
					mask_idx_d = mask_idx_inc;
					prem_d     = prem_dec;
					if ((opcode_q == OP_CONT) || (opcode_q == OP_BIN)) begin
						run_new    = 1'b1;
						run_d.data = unmasked;
					end else if (opcode_q == OP_PING) begin
						run_new          = 1'b1;
						run_d.chan_reply = 1'b1;
						run_d.data       = unmasked;
					end else if (opcode_q == OP_CLS) begin
						if (seen_q == 2'd0) begin
							code_d = {unmasked, 8'h00};
							seen_d = 2'd1;
						end else if (seen_q == 2'd1) begin
							code_d = {code_q[15:8], unmasked};
							seen_d = 2'd2;
						end
					end
					if (prem_dec == '0) begin
						phase_d  = PH_HDR0;
						peer_req = (opcode_q == OP_CLS);
					end
				end
				default: begin
					phase_d = PH_HDR0;
				end
			endcase
		end

		// Length complete: control frames must be final and short.
		if (ld_req) begin
			if (opcode_q[3] && (!fin_q || (ld_len > CTRL_MAX_LEN))) begin
				fin_req = 1'b1;
			end else begin
				mask_idx_d = 2'd0;
				key_d      = '0;
				phase_d    = PH_MASK;
			end
		end

		// Mask key complete: dispatch on the opcode.
		if (hd_req) begin
			code_d = CODE_NORMAL;
			seen_d = 2'd0;
			if (opcode_q == OP_TEXT) begin
				fin_req    = 1'b1;
				fin_code   = CODE_UNSUPP;
				fin_reason = END_TEXT;
			end else if (!op_known) begin
				fin_req = 1'b1;
			end else begin
				if (opcode_q == OP_PING) begin
					run_new    = 1'b1;
					run_d.kind = RUN_PONG;
					run_d.data = {1'b0, plen_q[6:0]};
				end
				prem_d = plen_q;
				if (plen_q == '0) begin
					phase_d  = PH_HDR0;
					peer_req = (opcode_q == OP_CLS);
				end else begin
					phase_d = PH_PAYLOAD;
				end
			end
		end

		if (peer_req) begin
			fin_req    = 1'b1;
			fin_code   = (seen_d == 2'd2) ? code_d : CODE_NORMAL;
			fin_reason = END_PEER;
		end

		if (fin_req) begin
			run_new      = 1'b1;
			run_d.kind   = RUN_CLOSE;
			run_d.code   = fin_code;
			run_d.reason = fin_reason;
			ended_d      = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ended_q    <= 1'b0;
			phase_q    <= PH_HDR0;
			opcode_q   <= OP_CONT;
			fin_q      <= 1'b0;
			len_left_q <= 4'd0;
			mask_idx_q <= 2'd0;
			seen_q     <= 2'd0;
			plen_q     <= '0;
			prem_q     <= '0;
			key_q      <= '0;
			code_q     <= CODE_NORMAL;
		end else if (accept) begin
			ended_q    <= ended_d;
			phase_q    <= phase_d;
			opcode_q   <= opcode_d;
			fin_q      <= fin_d;
			len_left_q <= len_left_d;
			mask_idx_q <= mask_idx_d;
			seen_q     <= seen_d;
			plen_q     <= plen_d;
			prem_q     <= prem_d;
			key_q      <= key_d;
			code_q     <= code_d;
		end
	end

	`WSD_ASSERT_NEXT(a_ended_sticky, clk, arst_n, ended_q, ended_q)
	`WSD_ASSERT(a_quiet_after_end, clk, arst_n, ended_q |-> !run_new)
	`WSD_ASSERT(a_payload_left, clk, arst_n, (phase_q == PH_PAYLOAD) |-> (prem_q != '0))

endmodule

>>> sv/wsd_emitter.sv
module wsd_emitter import wsd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load,
	input  run_t       run_d,
	output logic       busy,
	output logic       res_valid,
	input  logic       res_stall,
	output logic [1:0] channel,
	output logic [7:0] out_byte,
	output logic [1:0] end_reason,
	output logic       last_of_run
);

	`include "websocket_client_frame_deframer_assert.svh"

	run_t                 run_q;
	logic                 run_vld_q;
	logic [RUN_IDX_W-1:0] idx_q;
	logic                 take;
	logic                 done;

	assign res_valid = run_vld_q;
	assign take      = run_vld_q && !res_stall;
	assign done      = take && last_of_run;
	// Busy until the last beat of the current run leaves.
	assign busy      = run_vld_q && !done;

	always_comb begin
		channel     = CH_REPLY;
		out_byte    = 8'h00;
		end_reason  = END_NONE;
		last_of_run = 1'b0;
		case (run_q.kind)
			RUN_BYTE: begin
				channel     = run_q.chan_reply ? CH_REPLY : CH_DATA;
				out_byte    = run_q.data;
				last_of_run = 1'b1;
			end
			RUN_PONG: begin
				out_byte    = (idx_q == POS_FIRST) ? PONG_HDR : run_q.data;
				last_of_run = (idx_q == POS_SECOND);
			end
			RUN_CLOSE: begin
				case (idx_q)
					POS_FIRST:   out_byte = CLOSE_HDR;
					POS_SECOND:  out_byte = CLOSE_LEN;
					POS_CODE_HI: out_byte = run_q.code[15:8];
					POS_CODE_LO: out_byte = run_q.code[7:0];
					default: begin
						channel     = CH_END;
						end_reason  = run_q.reason;
						last_of_run = 1'b1;
					end
				endcase
			end
			default: begin
				last_of_run = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_vld_q <= 1'b0;
			idx_q     <= POS_FIRST;
		end else if (load) begin
			run_vld_q <= 1'b1;
			idx_q     <= POS_FIRST;
		end else if (done) begin
			run_vld_q <= 1'b0;
			idx_q     <= POS_FIRST;
		end else if (take) begin
			idx_q <= idx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			run_q <= run_d;
		end
	end

	`WSD_ASSERT(a_byte_single, clk, arst_n, (run_vld_q && run_q.kind == RUN_BYTE) |-> (idx_q == POS_FIRST))
	`WSD_ASSERT(a_close_pos, clk, arst_n, (run_vld_q && run_q.kind == RUN_CLOSE) |-> (idx_q <= POS_END))
	`WSD_ASSERT_NEXT(a_run_holds, clk, arst_n, take && !last_of_run, run_vld_q && $stable(run_q.kind))

endmodule

>>> tb/tb_websocket_client_frame_deframer.sv
module tb_websocket_client_frame_deframer;
	timeunit 1ns;
	timeprecision 1ps;

	import wsd_pkg::*;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int HOLD_CYCLES = 80;
	localparam int DRAIN_CYCLES = 20;
	localparam int MAX_REPORTS = 10;
	localparam int PHASE_BYTES = 15;

	// Length encodings for frames built by the stimulus.
	localparam int ENC_SHORT = 0;
	localparam int ENC_16 = 1;
	localparam int ENC_64 = 2;

	// Ways the connection is brought to its end.
	localparam int TERM_RSV = 0;
	localparam int TERM_UNMASKED = 1;
	localparam int TERM_HUGE = 2;
	localparam int TERM_BAD_CTRL = 3;
	localparam int TERM_TEXT = 4;
	localparam int TERM_UNKNOWN = 5;
	localparam int TERM_PEER = 6;

	typedef struct packed {
		logic [1:0] chan;
		logic [7:0] data;
		logic [1:0] reason;
		logic       last;
	} beat_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       rx_valid = 1'b0;
	logic       rx_stall;
	logic [7:0] rx_byte = 8'h00;
	logic       res_valid;
	logic       res_stall = 1'b0;
	logic [1:0] channel;
	logic [7:0] out_byte;
	logic [1:0] end_reason;
	logic       last_of_run;

	websocket_client_frame_deframer uut (
		.clk(clk),
		.arst_n(arst_n),
		.rx_valid(rx_valid),
		.rx_stall(rx_stall),
		.rx_byte(rx_byte),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.channel(channel),
		.out_byte(out_byte),
		.end_reason(end_reason),
		.last_of_run(last_of_run)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Bytes waiting to be offered, and result beats the block still owes.
	logic [7:0] rx_plan[$];
	beat_t      due_beats[$];
	int         n_planned = 0;

	int    sender_idle_pct = 0;
	int    recv_stall_pct = 0;
	int    hold_epoch = 0;
	int    hold_seen = 0;
	int    hold_left = 0;
	logic  rx_took = 1'b0;
	int    quiet = 0;
	int    n_fail = 0;
	int    n_sent = 0;
	int    n_data = 0;
	int    n_reply = 0;
	int    n_end = 0;
	string end_case = "none";

	// Parser state as the block should hold it.
	logic             st_ended = 1'b0;
	phase_t           st_phase = PH_HDR0;
	logic [3:0]       st_op = 4'h0;
	logic             st_fin = 1'b0;
	logic             st_rsv = 1'b0;
	logic [3:0]       st_len_left = 4'h0;
	logic [LEN_W-1:0] st_len = '0;
	logic [LEN_W-1:0] st_remain = '0;
	logic [31:0]      st_key = 32'h0;
	logic [1:0]       st_key_idx = 2'd0;
	logic [15:0]      st_code = CODE_NORMAL;
	int               st_code_bytes = 0;

	beat_t step_buf [0:4];
	int    step_n = 0;

	function automatic bit opcode_known(input logic [3:0] op);
		return op == OP_CONT || op == OP_BIN || op == OP_CLS || op == OP_PING || op == OP_PONG;
	endfunction

	task automatic emit(input logic [1:0] ch, input logic [7:0] d, input logic [1:0] why);
		step_buf[step_n] = '{chan: ch, data: d, reason: why, last: 1'b0};
		step_n++;
	endtask

	task automatic close_connection(input logic [15:0] code, input logic [1:0] why);
		emit(CH_REPLY, CLOSE_HDR, END_NONE);
		emit(CH_REPLY, CLOSE_LEN, END_NONE);
		emit(CH_REPLY, code[15:8], END_NONE);
		emit(CH_REPLY, code[7:0], END_NONE);
		emit(CH_END, 8'h00, why);
		st_ended = 1'b1;
	endtask

	// The peer's status code is echoed only when both of its bytes arrived.
	task automatic answer_peer_close();
		close_connection((st_code_bytes >= 2) ? st_code : CODE_NORMAL, END_PEER);
	endtask

	task automatic length_complete();
		if (st_op[3] && (!st_fin || st_len > CTRL_MAX_LEN)) begin
			close_connection(CODE_PROTOCOL, END_PROTO);
		end else begin
			st_key = 32'h0;
			st_key_idx = 2'd0;
			st_phase = PH_MASK;
		end
	endtask

	task automatic header_complete();
		st_code = CODE_NORMAL;
		st_code_bytes = 0;
		if (st_op == OP_TEXT) begin
			close_connection(CODE_UNSUPP, END_TEXT);
		end else if (!opcode_known(st_op)) begin
			close_connection(CODE_PROTOCOL, END_PROTO);
		end else begin
			if (st_op == OP_PING) begin
				emit(CH_REPLY, PONG_HDR, END_NONE);
				emit(CH_REPLY, {1'b0, st_len[6:0]}, END_NONE);
			end
			st_remain = st_len;
			if (st_len == 0) begin
				st_phase = PH_HDR0;
				if (st_op == OP_CLS)
					answer_peer_close();
			end else begin
				st_phase = PH_PAYLOAD;
			end
		end
	endtask

	task automatic deframe_byte(input logic [7:0] b);
		logic [7:0] plain;
		step_n = 0;
		if (!st_ended) begin
			case (st_phase)
				PH_HDR0: begin
					st_op = b[3:0];
					st_fin = b[7];
					st_rsv = |b[6:4];
					st_phase = PH_HDR1;
				end
				PH_HDR1: begin
					if (st_rsv || !b[7]) begin
						close_connection(CODE_PROTOCOL, END_PROTO);
					end else if (b[6:0] == LEN_EXT16) begin
						st_len = '0;
						st_len_left = EXT16_BYTES;
						st_phase = PH_EXTLEN;
					end else if (b[6:0] == LEN_EXT64) begin
						st_len = '0;
						st_len_left = EXT64_BYTES;
						st_phase = PH_EXTLEN;
					end else begin
						st_len = LEN_W'(b[6:0]);
						st_len_left = 4'h0;
						length_complete();
					end
				end
				PH_EXTLEN: begin
					if (st_len_left == EXT64_BYTES && b[7]) begin
						close_connection(CODE_PROTOCOL, END_PROTO);
					end else begin
						st_len = {st_len[LEN_W-9:0], b};
						st_len_left--;
						if (st_len_left == 0)
							length_complete();
					end
				end
				PH_MASK: begin
					st_key = {st_key[23:0], b};
					st_key_idx++;
					if (st_key_idx == 0)
						header_complete();
				end
				PH_PAYLOAD: begin
					plain = b ^ st_key[8 * (3 - st_key_idx) +: 8];
					st_key_idx++;
					st_remain = st_remain - 1'b1;
					if (st_op == OP_CONT || st_op == OP_BIN) begin
						emit(CH_DATA, plain, END_NONE);
					end else if (st_op == OP_PING) begin
						emit(CH_REPLY, plain, END_NONE);
					end else if (st_op == OP_CLS) begin
						if (st_code_bytes == 0) begin
							st_code = {plain, 8'h00};
							st_code_bytes = 1;
						end else if (st_code_bytes == 1) begin
							st_code[7:0] = plain;
							st_code_bytes = 2;
						end
					end
					if (st_remain == 0) begin
						st_phase = PH_HDR0;
						if (st_op == OP_CLS)
							answer_peer_close();
					end
				end
				default: st_phase = PH_HDR0;
			endcase
		end
		if (step_n > 0)
			step_buf[step_n - 1].last = 1'b1;
		for (int i = 0; i < step_n; i++)
			due_beats.push_back(step_buf[i]);
	endtask

	task automatic queue_byte(input logic [7:0] b);
		rx_plan.push_back(b);
		n_planned++;
	endtask

	task automatic add_frame(input logic [3:0] op, input logic fin, input int unsigned len,
			input int enc, input logic [31:0] key, input bit fixed, input logic [7:0] fill);
		logic [63:0] len64;
		len64 = 64'(len);
		queue_byte({fin, 3'b000, op});
		if (enc == ENC_16) begin
			queue_byte({1'b1, LEN_EXT16});
			queue_byte(len64[15:8]);
			queue_byte(len64[7:0]);
		end else if (enc == ENC_64) begin
			queue_byte({1'b1, LEN_EXT64});
			for (int i = 7; i >= 0; i--)
				queue_byte(len64[8 * i +: 8]);
		end else begin
			queue_byte({1'b1, len64[6:0]});
		end
		for (int i = 3; i >= 0; i--)
			queue_byte(key[8 * i +: 8]);
		for (int i = 0; i < len; i++)
			queue_byte(fixed ? fill : 8'($urandom));
	endtask

	// Well-formed frames only; mostly short payloads with an occasional longer one.
	task automatic add_random_frames(input int min_bytes);
		logic [3:0]  op;
		int          pick;
		int unsigned len;
		int          enc;
		int          target;
		target = n_planned + min_bytes;
		while (n_planned < target) begin
			pick = $urandom_range(99);
			if (pick < 40)
				op = OP_BIN;
			else if (pick < 60)
				op = OP_CONT;
			else if (pick < 80)
				op = OP_PING;
			else
				op = OP_PONG;
			len = ($urandom_range(9) == 0) ? $urandom_range(24, 13) : $urandom_range(6, 0);
			pick = $urandom_range(9);
			enc = (pick < 7) ? ENC_SHORT : ((pick < 9) ? ENC_16 : ENC_64);
			add_frame(op, op[3] ? 1'b1 : 1'($urandom_range(1)), len, enc, $urandom, 1'b0, 8'h00);
		end
	endtask

	task automatic wait_drained();
		while (rx_plan.size() != 0 || rx_valid)
			@(posedge clk);
		while (due_beats.size() != 0)
			@(posedge clk);
	endtask

	always @(negedge clk) begin : byte_driver
		if (arst_n && (!rx_valid || rx_took)) begin
			if (rx_plan.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
				rx_valid <= 1'b1;
				rx_byte <= rx_plan.pop_front();
			end else begin
				rx_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin : result_stall
		if (hold_seen != hold_epoch) begin
			hold_seen = hold_epoch;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			res_stall <= 1'b1;
			hold_left--;
		end else begin
			res_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin : monitor
		beat_t want;
		rx_took <= arst_n && rx_valid && !rx_stall;
		if (arst_n) begin
			// Predict first so that a byte and its results never race.
			if (rx_valid && !rx_stall) begin
				deframe_byte(rx_byte);
				n_sent++;
			end
			if (res_valid && !res_stall) begin
				if (channel == CH_DATA)
					n_data++;
				else if (channel == CH_REPLY)
					n_reply++;
				else
					n_end++;
				if (due_beats.size() == 0) begin
					n_fail++;
					if (n_fail <= MAX_REPORTS)
						$display("Unexpected result beat: ch %0d byte %02h reason %0d last %0b",
							channel, out_byte, end_reason, last_of_run);
				end else begin
					want = due_beats.pop_front();
					if (channel !== want.chan || out_byte !== want.data ||
							end_reason !== want.reason || last_of_run !== want.last) begin
						n_fail++;
						if (n_fail <= MAX_REPORTS) begin
							$display("Mismatch: expected ch %0d byte %02h reason %0d last %0b,",
								want.chan, want.data, want.reason, want.last);
							$display("  got ch %0d byte %02h reason %0d last %0b",
								channel, out_byte, end_reason, last_of_run);
						end
					end
				end
			end
			if ((rx_valid && !rx_stall) || (res_valid && !res_stall))
				quiet = 0;
			else
				quiet++;
			if (quiet >= WATCHDOG_LIMIT) begin
				$display("Timeout: no beat moved for %0d cycles", quiet);
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	initial begin : stimulus
		logic [3:0]  op;
		logic [15:0] long_len;
		int          term;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// Hand-picked frames: all-zero and all-ones bytes, every accepted opcode but close,
		// an empty ping and both extended length forms.
		add_frame(OP_BIN, 1'b1, 2, ENC_SHORT, 32'hFFFF_FFFF, 1'b1, 8'hFF);
		add_frame(OP_CONT, 1'b0, 1, ENC_SHORT, 32'h0000_0000, 1'b1, 8'hFF);
		add_frame(OP_PING, 1'b1, 0, ENC_SHORT, $urandom, 1'b0, 8'h00);
		add_frame(OP_PING, 1'b1, 3, ENC_16, $urandom, 1'b0, 8'h00);
		add_frame(OP_PONG, 1'b1, 1, ENC_SHORT, $urandom, 1'b0, 8'h00);
		add_frame(OP_BIN, 1'b1, 1, ENC_64, $urandom, 1'b0, 8'h00);
		// The output is held off for a long stretch while bytes keep coming.
		hold_epoch++;
		add_random_frames(PHASE_BYTES);
		wait_drained();

		sender_idle_pct = 69;
		add_random_frames(PHASE_BYTES);
		wait_drained();

		sender_idle_pct = 0;
		recv_stall_pct = 69;
		add_random_frames(PHASE_BYTES);
		wait_drained();

		sender_idle_pct = 15;
		recv_stall_pct = 15;
		add_random_frames(PHASE_BYTES);
		// Only one way to end the connection fits in a run; the seed picks it.
		term = $urandom_range(TERM_PEER, TERM_RSV);
		case (term)
			TERM_RSV: begin
				end_case = "reserved bits set";
				queue_byte({1'($urandom_range(1)), 3'($urandom_range(7, 1)), OP_BIN});
				queue_byte({1'b1, 7'($urandom_range(125))});
			end
			TERM_UNMASKED: begin
				end_case = "unmasked frame";
				queue_byte({1'b1, 3'b000, OP_BIN});
				queue_byte({1'b0, 7'($urandom)});
			end
			TERM_HUGE: begin
				end_case = "64-bit length with top bit set";
				queue_byte({1'b1, 3'b000, OP_BIN});
				queue_byte({1'b1, LEN_EXT64});
				queue_byte(8'h80 | 8'($urandom));
			end
			TERM_BAD_CTRL: begin
				end_case = "malformed control frame";
				op = {1'b1, 3'($urandom)};
				if ($urandom_range(1) == 1) begin
					queue_byte({1'b0, 3'b000, op});
					queue_byte({1'b1, 7'($urandom_range(125))});
				end else begin
					long_len = 16'($urandom_range(65535, 126));
					queue_byte({1'b1, 3'b000, op});
					queue_byte({1'b1, LEN_EXT16});
					queue_byte(long_len[15:8]);
					queue_byte(long_len[7:0]);
				end
			end
			TERM_TEXT: begin
				end_case = "text frame";
				add_frame(OP_TEXT, 1'($urandom_range(1)), $urandom_range(6), ENC_SHORT,
					$urandom, 1'b0, 8'h00);
			end
			TERM_UNKNOWN: begin
				end_case = "unknown opcode";
				do
					op = 4'($urandom);
				while (opcode_known(op) || op == OP_TEXT);
				add_frame(op, 1'b1, $urandom_range(6), ENC_SHORT, $urandom, 1'b0, 8'h00);
			end
			default: begin
				end_case = "peer close";
				add_frame(OP_CLS, 1'b1, $urandom_range(5), ENC_SHORT, $urandom, 1'b0, 8'h00);
			end
		endcase
		// The block must swallow these once the connection has ended.
		repeat (8) queue_byte(8'($urandom));
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Summary: %0d bytes sent over four pacing phases with a %0d-cycle output hold;",
			n_sent, HOLD_CYCLES);
		$display("  %0d data, %0d reply and %0d end beats checked; connection ended by %s.",
			n_data, n_reply, n_end, end_case);
		if (due_beats.size() != 0)
			$display("%0d expected result beats never arrived", due_beats.size());
		if (n_fail == 0 && due_beats.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d result errors", n_fail);
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
